@@ rtl/slotalloc_pkg.sv @@
package slotalloc_pkg;

    localparam int SLOTS_DEF = 256;

    localparam int FUNC_W = 2;
    localparam int IDX_W  = 8;
    localparam int CAP_W  = 9;
    localparam int STAT_W = 2;
    localparam int LT_W   = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_QUERY   = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

@@ rtl/slotalloc_ram.sv @@
module slotalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word when no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/slot_allocator_with_live_map_core.sv @@
// Slot allocator: each operation word (allocate, release, query) goes through
// a registered read of the free-queue and live-bit memories and then an update
// and write-back; a new word is taken in only after the last is written back,
// which waits while an older result is unread. An allocate reuses the oldest
// released slot and otherwise takes the next never-used slot; a finished
// result waits in an output register while the next word is taken in. The
// live bits need no clearing pass after reset: a slot at or above the
// high-water mark always reads as not live, so the block is ready as soon as
// reset ends. Write slot_capacity only while no word is in flight.
module slot_allocator_with_live_map_core
    import slotalloc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_slot_capacity,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [IDX_W-1:0]  i_slot_index,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_W-1:0]  o_granted_slot,
    output logic              o_slot_live,
    output logic [STAT_W-1:0] o_status,
    output logic [LT_W-1:0]   o_live_total
);

    localparam int PW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WW = (CW > CAP_W) ? CW : CAP_W;

    t_state r_state, n_state;

    logic [CAP_W-1:0]  r_capacity;
    logic [PW-1:0]     r_head, n_head;
    logic [PW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_queue_count, n_queue_count;
    logic [CW-1:0]     r_high_water, n_high_water;
    logic [FUNC_W-1:0] r_func;
    logic [IDX_W-1:0]  r_idx;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_granted, n_granted;
    logic              r_live, n_live;
    logic [STAT_W-1:0] r_status, n_status;
    logic [CW-1:0]     r_live_total;

    logic in_accept;
    logic out_free;
    logic commit;
    logic rd_en;

    logic             q_we;
    logic [IDX_W-1:0] q_rdata;
    logic             lm_we;
    logic [PW-1:0]    lm_waddr;
    logic             lm_wdata;
    logic             lm_rdata;

    logic [CW-1:0] live_cnt;
    logic [WW-1:0] limit;
    logic          idx_in_pool;
    logic          idx_below_hw;

    slotalloc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (r_idx),
        .i_re    (rd_en),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    slotalloc_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (lm_we),
        .i_waddr (lm_waddr),
        .i_wdata (lm_wdata),
        .i_re    (rd_en),
        .i_raddr (PW'(i_slot_index)),
        .o_rdata (lm_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        commit     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_EXEC: commit     = out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign rd_en = in_accept;

    assign live_cnt     = r_high_water - r_queue_count;
    assign limit        = (WW'(r_capacity) < WW'(SLOTS)) ? WW'(r_capacity) : WW'(SLOTS);
    assign idx_in_pool  = WW'(r_idx) < WW'(SLOTS);
    assign idx_below_hw = WW'(r_idx) < WW'(r_high_water);

    // operation datapath, applied on commit
    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_queue_count = r_queue_count;
        n_high_water  = r_high_water;
        n_granted     = '0;
        n_live        = 1'b0;
        n_status      = STAT_OK;
        q_we          = 1'b0;
        lm_we         = 1'b0;
        lm_waddr      = PW'(r_idx);
        lm_wdata      = 1'b0;
        case (r_func)
            FUNC_ALLOC: begin
                if (WW'(live_cnt) >= limit) begin
                    n_status = STAT_FULL;
                end else begin
                    n_live = 1'b1;
                    lm_we  = commit;
                    lm_wdata = 1'b1;
                    if (r_queue_count != '0) begin
                        n_granted     = q_rdata;
                        lm_waddr      = PW'(q_rdata);
                        n_head        = (r_head == PW'(SLOTS - 1)) ? '0 : r_head + 1'b1;
                        n_queue_count = r_queue_count - 1'b1;
                    end else begin
                        n_granted    = IDX_W'(r_high_water);
                        lm_waddr     = PW'(r_high_water);
                        n_high_water = r_high_water + 1'b1;
                    end
                end
            end
            FUNC_RELEASE: begin
                if (idx_below_hw && idx_in_pool && lm_rdata) begin
                    q_we          = commit;
                    lm_we         = commit;
                    n_tail        = (r_tail == PW'(SLOTS - 1)) ? '0 : r_tail + 1'b1;
                    n_queue_count = r_queue_count + 1'b1;
                end else begin
                    n_status = STAT_BAD;
                end
            end
            FUNC_QUERY: begin
                if (idx_in_pool) begin
                    // slots at or above the high-water mark were never written
                    n_live = idx_below_hw && lm_rdata;
                end else begin
                    n_status = STAT_BAD;
                end
            end
            default: n_status = STAT_BAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_capacity    <= CAP_RESET;
            r_head        <= '0;
            r_tail        <= '0;
            r_queue_count <= '0;
            r_high_water  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_slot_capacity;
            end
            if (commit) begin
                r_head        <= n_head;
                r_tail        <= n_tail;
                r_queue_count <= n_queue_count;
                r_high_water  <= n_high_water;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func <= i_func;
            r_idx  <= i_slot_index;
        end
        if (commit) begin
            r_granted    <= n_granted;
            r_live       <= n_live;
            r_status     <= n_status;
            r_live_total <= n_high_water - n_queue_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted_slot = r_granted;
    assign o_slot_live    = r_live;
    assign o_status       = r_status;
    assign o_live_total   = LT_W'(r_live_total);

    a_count_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_queue_count <= r_high_water) && (r_high_water <= CW'(SLOTS)))
        else $error("free queue count or high-water mark out of range");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !o_out_valid) |-> ##2 o_out_valid)
        else $error("result word not presented two cycles after accept");

    a_no_grant_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_OK)) |-> (o_granted_slot == '0 && !o_slot_live))
        else $error("failed operation reports a slot");

endmodule

@@ test/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slotalloc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 10;

    typedef struct packed {
        logic [IDX_W-1:0] granted;
        logic             live;
        t_status          status;
        logic [LT_W-1:0]  total;
    } t_answer;

    // how the sender fills in a word when it raises valid
    typedef enum {
        K_FIXED,
        K_ALLOC,
        K_REL_LIVE,
        K_REL_ANY,
        K_QUERY,
        K_UNKNOWN
    } t_kind;

    typedef struct {
        t_kind             kind;
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  idx;
    } t_plan;

    class slot_ledger;
        logic [CAP_W-1:0] capacity;
        logic [IDX_W-1:0] free_slots[$];
        int unsigned      high_water;
        bit [SLOTS_DEF-1:0] live_bits;
        t_answer          answers_due[$];
        int unsigned      errors, checked, peak_live;
        int unsigned      n_alloc, n_full, n_release, n_refused, n_query, n_unknown;

        function new();
            capacity   = CAP_RESET;
            high_water = 0;
            live_bits  = '0;
            errors = 0; checked = 0; peak_live = 0;
            n_alloc = 0; n_full = 0; n_release = 0; n_refused = 0;
            n_query = 0; n_unknown = 0;
        endfunction

        function int unsigned live_now();
            return high_water - free_slots.size();
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        function bit pick_live(output logic [IDX_W-1:0] slot);
            logic [IDX_W-1:0] held[$];
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (live_bits[i]) held.insert(held.size(), IDX_W'(i));
            end
            slot = '0;
            if (held.size() == 0) return 0;
            slot = held[$urandom_range(0, held.size() - 1)];
            return 1;
        endfunction

        // predict the answer to an accepted word and advance the slot state
        function void log_word(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx);
            t_answer     ans;
            int unsigned limit;
            logic [IDX_W-1:0] slot;
            ans.granted = '0;
            ans.live    = 1'b0;
            ans.status  = STAT_OK;
            limit = (capacity > SLOTS_DEF) ? SLOTS_DEF : capacity;
            case (func)
                FUNC_ALLOC: begin
                    n_alloc++;
                    if (live_now() >= limit) begin
                        ans.status = STAT_FULL;
                        n_full++;
                    end else begin
                        if (free_slots.size() > 0) begin
                            slot = free_slots.pop_front();
                        end else begin
                            slot = high_water[IDX_W-1:0];
                            high_water++;
                        end
                        live_bits[slot] = 1'b1;
                        ans.granted = slot;
                        ans.live    = 1'b1;
                    end
                end
                FUNC_RELEASE: begin
                    n_release++;
                    if (idx < high_water && live_bits[idx]) begin
                        free_slots.insert(free_slots.size(), idx);
                        live_bits[idx] = 1'b0;
                    end else begin
                        ans.status = STAT_BAD;
                        n_refused++;
                    end
                end
                FUNC_QUERY: begin
                    n_query++;
                    ans.live = live_bits[idx];
                end
                default: begin
                    n_unknown++;
                    ans.status = STAT_BAD;
                end
            endcase
            ans.total = LT_W'(live_now());
            if (live_now() > peak_live) peak_live = live_now();
            answers_due.insert(answers_due.size(), ans);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_answer(logic [IDX_W-1:0] granted, logic live,
                                   logic [STAT_W-1:0] status, logic [LT_W-1:0] total);
            t_answer want;
            if (answers_due.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected: %s %0d %0d %0d %0d",
                         $time, "slot/live/status/total", granted, live, status, total);
                return;
            end
            want = answers_due.pop_front();
            checked++;
            compare("granted_slot", want.granted, granted);
            compare("slot_live", want.live, live);
            compare("status", want.status, status);
            compare("live_total", want.total, total);
        endfunction

        function void close_out();
            if (answers_due.size() != 0) begin
                errors += answers_due.size();
                $display("%0t: %0d expected result words never arrived",
                         $time, answers_due.size());
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CAP_W-1:0]  i_cfg_slot_capacity;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [FUNC_W-1:0] i_func;
    logic [IDX_W-1:0]  i_slot_index;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [IDX_W-1:0]  o_granted_slot;
    logic              o_slot_live;
    logic [STAT_W-1:0] o_status;
    logic [LT_W-1:0]   o_live_total;

    slot_ledger  ledger;
    t_plan       plan_q[$];
    int unsigned words_planned = 0;
    int unsigned words_sent = 0;
    int unsigned cap_writes = 0;
    int unsigned cycles = 0;
    bit          sender_calm = 1'b0;
    bit          recv_calm = 1'b0;
    bit          hold_req = 1'b0;

    slot_allocator_with_live_map_core u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_slot_capacity (i_cfg_slot_capacity),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_slot_index        (i_slot_index),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_granted_slot      (o_granted_slot),
        .o_slot_live         (o_slot_live),
        .o_status            (o_status),
        .o_live_total        (o_live_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int draw_wait();
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
    endfunction

    // sender: raise one planned word at a time, hold it until accepted
    initial begin : sender
        t_plan            p;
        int               gap_left;
        logic [IDX_W-1:0] idx;
        gap_left     = 0;
        i_in_valid   = 1'b0;
        i_func       = FUNC_ALLOC;
        i_slot_index = '0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (gap_left > 0 || plan_q.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                p = plan_q.pop_front();
                idx = $urandom_range(0, SLOTS_DEF - 1);
                case (p.kind)
                    K_FIXED:    idx = p.idx;
                    K_ALLOC:    p.func = FUNC_ALLOC;
                    K_REL_ANY:  p.func = FUNC_RELEASE;
                    K_UNKNOWN:  p.func = FUNC_UNKNOWN;
                    K_REL_LIVE: begin
                        p.func = FUNC_RELEASE;
                        void'(ledger.pick_live(idx));
                    end
                    default: begin
                        p.func = FUNC_QUERY;
                        if ($urandom_range(0, 1)) void'(ledger.pick_live(idx));
                    end
                endcase
                if (!ledger.pick_live(p.idx) && p.kind == K_REL_LIVE) begin
                    idx = $urandom_range(0, SLOTS_DEF - 1);
                end
                i_in_valid   <= 1'b1;
                i_func       <= p.func;
                i_slot_index <= idx;
                @(posedge i_clk);
                while (!o_in_ready) @(posedge i_clk);
                ledger.log_word(p.func, idx);
                words_sent++;
                gap_left = sender_calm ? 0 : draw_wait();
            end
        end
    end

    // receiver: stall per word, or hold off for a long stretch on request
    initial begin : receiver
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = recv_calm ? 0 : draw_wait();
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            ledger.check_answer(o_granted_slot, o_slot_live, o_status, o_live_total);
        end
    end

    task automatic plan_fixed(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx);
        t_plan p;
        p.kind = K_FIXED;
        p.func = func;
        p.idx  = idx;
        plan_q.insert(plan_q.size(), p);
        words_planned++;
    endtask

    task automatic plan_random(input int count, input int alloc_pct);
        t_plan p;
        int    roll;
        for (int i = 0; i < count; i++) begin
            p.func = FUNC_ALLOC;
            p.idx  = '0;
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct) begin
                p.kind = K_ALLOC;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60)      p.kind = K_REL_LIVE;
                else if (roll < 70) p.kind = K_REL_ANY;
                else if (roll < 95) p.kind = K_QUERY;
                else                p.kind = K_UNKNOWN;
            end
            plan_q.insert(plan_q.size(), p);
            words_planned++;
        end
    endtask

    task automatic wait_idle();
        while (words_sent != words_planned || ledger.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_slot_capacity <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.capacity = cap;
        cap_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned caps[PHASES];
        int unsigned sizes[PHASES];
        int unsigned pcts[PHASES];
        ledger = new();
        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_slot_capacity = CAP_RESET;
        caps  = '{1, 0, 2, 40, 511, 255, 256, 300, 0, 3};
        sizes = '{60, 40, 60, 100, 300, 80, 80, 60, 60, 60};
        pcts  = '{60, 40, 50, 60, 90, 40, 60, 50, 50, 30};
        caps[8] = $urandom_range(3, 256);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fresh pool: empty map, refused release, unknown op, reuse order
        plan_fixed(FUNC_QUERY, 8'd0);
        plan_fixed(FUNC_RELEASE, 8'd0);
        plan_fixed(FUNC_UNKNOWN, 8'hFF);
        repeat (4) plan_fixed(FUNC_ALLOC, 8'hFF);
        plan_fixed(FUNC_QUERY, 8'hFF);
        plan_fixed(FUNC_RELEASE, 8'd1);
        plan_fixed(FUNC_RELEASE, 8'd1);
        plan_fixed(FUNC_RELEASE, 8'd3);
        repeat (3) plan_fixed(FUNC_ALLOC, 8'h00);
        plan_fixed(FUNC_QUERY, 8'd3);
        plan_fixed(FUNC_QUERY, 8'd1);
        plan_fixed(FUNC_RELEASE, 8'd200);
        plan_fixed(FUNC_UNKNOWN, 8'hAA);

        // capacity equal to the live count, then zero, then one
        write_capacity(9'd5);
        plan_fixed(FUNC_ALLOC, 8'd0);
        plan_fixed(FUNC_RELEASE, 8'd2);
        plan_fixed(FUNC_ALLOC, 8'd0);
        plan_fixed(FUNC_ALLOC, 8'd0);
        write_capacity(9'd0);
        plan_fixed(FUNC_ALLOC, 8'd0);
        plan_fixed(FUNC_RELEASE, 8'd4);
        plan_fixed(FUNC_QUERY, 8'd4);
        write_capacity(9'd1);
        plan_fixed(FUNC_ALLOC, 8'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_capacity(CAP_W'(caps[ph]));
            sender_calm = (ph % 3 == 1) || (ph == 3);
            recv_calm   = (ph % 4 == 2);
            if (ph == 3) begin
                // stall the result side while words keep coming
                hold_req = 1'b1;
                plan_random(sizes[ph], pcts[ph]);
            end else if (ph == 4) begin
                // fill the whole pool, pausing halfway until all answers are in
                plan_random(sizes[ph] / 2, pcts[ph]);
                wait_idle();
                plan_random(sizes[ph] - sizes[ph] / 2, pcts[ph]);
            end else begin
                plan_random(sizes[ph], pcts[ph]);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        ledger.close_out();
        $display("tb: %0d words checked over %0d capacity settings: %0d allocate (%0d full),",
                 ledger.checked, cap_writes, ledger.n_alloc, ledger.n_full);
        $display("tb: %0d release (%0d refused), %0d query, %0d unknown op, %s %0d, %s %0d",
                 ledger.n_release, ledger.n_refused, ledger.n_query, ledger.n_unknown,
                 "peak live", ledger.peak_live, "high-water", ledger.high_water);
        if (ledger.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ slot_allocator_with_live_map_core.f @@
rtl/slotalloc_pkg.sv
rtl/slotalloc_ram.sv
rtl/slot_allocator_with_live_map_core.sv
test/testbench.sv
